// ===== sv/rvalu_pkg.sv =====
// Shared types, operation codes and helpers for the RV64IM integer ALU.
package rvalu_pkg;

   localparam int XLEN = 64;
   localparam int HLEN = XLEN / 2;
   localparam int OPW  = 5;

   typedef enum logic [OPW-1:0] {
      OP_ADD    = 5'd0,
      OP_SUB    = 5'd1,
      OP_SLL    = 5'd2,
      OP_SLT    = 5'd3,
      OP_SLTU   = 5'd4,
      OP_XOR    = 5'd5,
      OP_SRL    = 5'd6,
      OP_SRA    = 5'd7,
      OP_OR     = 5'd8,
      OP_AND    = 5'd9,
      OP_MUL    = 5'd10,
      OP_MULH   = 5'd11,
      OP_MULHSU = 5'd12,
      OP_MULHU  = 5'd13,
      OP_DIV    = 5'd14,
      OP_DIVU   = 5'd15,
      OP_REM    = 5'd16,
      OP_REMU   = 5'd17,
      OP_ADDW   = 5'd18,
      OP_SUBW   = 5'd19,
      OP_SLLW   = 5'd20,
      OP_SRLW   = 5'd21,
      OP_SRAW   = 5'd22,
      OP_MULW   = 5'd23,
      OP_DIVW   = 5'd24,
      OP_DIVUW  = 5'd25,
      OP_REMW   = 5'd26,
      OP_REMUW  = 5'd27
   } op_type;

   typedef struct packed {
      logic [OPW-1:0]  op;
      logic [XLEN-1:0] res;
      logic [XLEN-1:0] rem;
      logic [XLEN-1:0] quo;
      logic [XLEN-1:0] dvs;
      logic            neg_q;
      logic            neg_r;
   } stage_type;

   typedef struct packed {
      logic [XLEN-1:0] ll;
      logic [XLEN-1:0] lh;
      logic [XLEN-1:0] hl;
      logic [XLEN-1:0] hh;
      logic [XLEN-1:0] corr;
   } mul_type;

   function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
      sext32 = {{(XLEN-HLEN){v[HLEN-1]}}, v[HLEN-1:0]};
   endfunction

endpackage

// ===== sv/rvalu_req_if.sv =====
// Request channel: operation code and two operands.
interface rvalu_req_if
   import rvalu_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [OPW-1:0]  req_type;
   logic [XLEN-1:0] operand_a;
   logic [XLEN-1:0] operand_b;

   modport source (output valid, req_type, operand_a, operand_b, input ready);
   modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

// ===== sv/rvalu_rsp_if.sv =====
// Response channel: one result word.
interface rvalu_rsp_if
   import rvalu_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [XLEN-1:0] result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

// ===== sv/rv64im_integer_alu.sv =====
// RV64IM integer ALU: entry stage, two multiply stages, 64 divider cells, exit stage.
// Every operation passes through every stage, in order: entry, multiply, divide cells, exit.
// Throughput: one word per cycle; the whole pipeline holds while a result waits unread.
// Divide throughput comes from one restoring-division cell per quotient bit.
// Reset: synchronous, active high; clears all stage valid bits, pipeline empties.
module rv64im_integer_alu
   import rvalu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rvalu_req_if.sink   req_ch,
   rvalu_rsp_if.source rsp_ch
);
   logic            adv;
   logic            prep_valid, mul_valid;
   stage_type       prep_st, mul_st;
   mul_type         prep_mul;
   logic [XLEN:0]   cell_valid;
   stage_type       cell_st [XLEN+1];

   assign adv          = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   rvalu_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_ch.valid),
      .in_op     (req_ch.req_type),
      .in_a      (req_ch.operand_a),
      .in_b      (req_ch.operand_b),
      .out_valid (prep_valid),
      .out_st    (prep_st),
      .out_mul   (prep_mul)
   );

   rvalu_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (prep_valid),
      .in_st     (prep_st),
      .in_mul    (prep_mul),
      .out_valid (mul_valid),
      .out_st    (mul_st)
   );

   assign cell_valid[0] = mul_valid;
   assign cell_st[0]    = mul_st;

   for (genvar i = 0; i < XLEN; i++) begin : g_cell
      rvalu_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (cell_valid[i]),
         .in_st     (cell_st[i]),
         .out_valid (cell_valid[i+1]),
         .out_st    (cell_st[i+1])
      );
   end

   rvalu_post u_post (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (cell_valid[XLEN]),
      .in_st      (cell_st[XLEN]),
      .out_valid  (rsp_ch.valid),
      .out_result (rsp_ch.result)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while pipeline is stalled");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(cell_valid) && $stable(prep_valid) && $stable(mul_valid))
      else $error("pipeline occupancy changed during stall");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(cell_st[XLEN]))
      else $error("last divider cell changed during stall");
endmodule

// ===== sv/rvalu_prep.sv =====
// Entry stage: simple ALU ops, partial products and divider operand setup.
module rvalu_prep
   import rvalu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [OPW-1:0]  in_op,
   input  logic [XLEN-1:0] in_a,
   input  logic [XLEN-1:0] in_b,
   output logic            out_valid,
   output stage_type       out_st,
   output mul_type         out_mul
);
   logic            valid_ff;
   stage_type       st_ff, st_in;
   mul_type         mul_ff, mul_in;
   op_type          op;
   logic [HLEN-1:0] sl32, sr32, sa32;
   logic [XLEN-1:0] a_x, b_x, a_sum, a_dif;
   logic            is_w, is_sgn, na, nb;

   assign op = op_type'(in_op);

   always_comb begin
      sl32  = in_a[HLEN-1:0] << in_b[4:0];
      sr32  = in_a[HLEN-1:0] >> in_b[4:0];
      sa32  = $signed(in_a[HLEN-1:0]) >>> in_b[4:0];
      a_sum = in_a + in_b;
      a_dif = in_a - in_b;
      is_w   = (op == OP_DIVW) || (op == OP_DIVUW) || (op == OP_REMW) || (op == OP_REMUW);
      is_sgn = (op == OP_DIV) || (op == OP_REM) || (op == OP_DIVW) || (op == OP_REMW);
      a_x = is_w ? (is_sgn ? sext32(in_a) : {{(XLEN-HLEN){1'b0}}, in_a[HLEN-1:0]}) : in_a;
      b_x = is_w ? (is_sgn ? sext32(in_b) : {{(XLEN-HLEN){1'b0}}, in_b[HLEN-1:0]}) : in_b;
      na  = is_sgn && a_x[XLEN-1];
      nb  = is_sgn && b_x[XLEN-1];

      st_in       = '0;
      st_in.op    = in_op;
      st_in.quo   = na ? (XLEN'(0) - a_x) : a_x;
      st_in.dvs   = nb ? (XLEN'(0) - b_x) : b_x;
      st_in.neg_q = (na ^ nb) && (b_x != '0);
      st_in.neg_r = na;
      unique case (op)
         OP_ADD:  st_in.res = a_sum;
         OP_SUB:  st_in.res = a_dif;
         OP_SLL:  st_in.res = in_a << in_b[5:0];
         OP_SLT:  st_in.res = XLEN'($signed(in_a) < $signed(in_b));
         OP_SLTU: st_in.res = XLEN'(in_a < in_b);
         OP_XOR:  st_in.res = in_a ^ in_b;
         OP_SRL:  st_in.res = in_a >> in_b[5:0];
         OP_SRA:  st_in.res = $signed(in_a) >>> in_b[5:0];
         OP_OR:   st_in.res = in_a | in_b;
         OP_AND:  st_in.res = in_a & in_b;
         OP_ADDW: st_in.res = sext32(a_sum);
         OP_SUBW: st_in.res = sext32(a_dif);
         OP_SLLW: st_in.res = sext32({{(XLEN-HLEN){1'b0}}, sl32});
         OP_SRLW: st_in.res = sext32({{(XLEN-HLEN){1'b0}}, sr32});
         OP_SRAW: st_in.res = sext32({{(XLEN-HLEN){1'b0}}, sa32});
         default: st_in.res = '0;
      endcase

      mul_in.ll = in_a[HLEN-1:0] * in_b[HLEN-1:0];
      mul_in.lh = in_a[HLEN-1:0] * in_b[XLEN-1:HLEN];
      mul_in.hl = in_a[XLEN-1:HLEN] * in_b[HLEN-1:0];
      mul_in.hh = in_a[XLEN-1:HLEN] * in_b[XLEN-1:HLEN];
      unique case (op)
         OP_MULH:   mul_in.corr = (in_a[XLEN-1] ? in_b : '0) + (in_b[XLEN-1] ? in_a : '0);
         OP_MULHSU: mul_in.corr = in_a[XLEN-1] ? in_b : '0;
         default:   mul_in.corr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         st_ff  <= st_in;
         mul_ff <= mul_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_st    = st_ff;
   assign out_mul   = mul_ff;
endmodule

// ===== sv/rvalu_mul.sv =====
// Two-stage multiply combine: partial product sum, then sign correction and select.
module rvalu_mul
   import rvalu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      in_valid,
   input  stage_type in_st,
   input  mul_type   in_mul,
   output logic      out_valid,
   output stage_type out_st
);
   logic              v1_ff, v2_ff;
   stage_type         st1_ff, st2_ff, st2_in;
   logic [2*XLEN-1:0] prod_ff, prod_in;
   logic [XLEN-1:0]   corr_ff;

   always_comb begin
      prod_in = {in_mul.hh, in_mul.ll}
              + {{HLEN{1'b0}}, in_mul.lh, {HLEN{1'b0}}}
              + {{HLEN{1'b0}}, in_mul.hl, {HLEN{1'b0}}};
      st2_in = st1_ff;
      unique case (op_type'(st1_ff.op))
         OP_MUL:    st2_in.res = prod_ff[XLEN-1:0];
         OP_MULH,
         OP_MULHSU,
         OP_MULHU:  st2_in.res = prod_ff[2*XLEN-1:XLEN] - corr_ff;
         OP_MULW:   st2_in.res = sext32(prod_ff[XLEN-1:0]);
         default:   st2_in.res = st1_ff.res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         st1_ff  <= in_st;
         prod_ff <= prod_in;
         corr_ff <= in_mul.corr;
         st2_ff  <= st2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_st    = st2_ff;
endmodule

// ===== sv/rvalu_div_cell.sv =====
// One restoring-division step: shift in a dividend bit, subtract if it fits.
module rvalu_div_cell
   import rvalu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      in_valid,
   input  stage_type in_st,
   output logic      out_valid,
   output stage_type out_st
);
   logic            valid_ff;
   stage_type       st_ff, st_in;
   logic [XLEN:0]   trial;
   logic [XLEN+1:0] diff;

   always_comb begin
      trial = {in_st.rem, in_st.quo[XLEN-1]};
      diff  = {1'b0, trial} - {2'b00, in_st.dvs};
      st_in = in_st;
      st_in.rem = diff[XLEN+1] ? trial[XLEN-1:0] : diff[XLEN-1:0];
      st_in.quo = {in_st.quo[XLEN-2:0], ~diff[XLEN+1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_st    = st_ff;
endmodule

// ===== sv/rvalu_post.sv =====
// Exit stage: divider sign fixup, W sign extension and result register.
module rvalu_post
   import rvalu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  stage_type       in_st,
   output logic            out_valid,
   output logic [XLEN-1:0] out_result
);
   logic            valid_ff;
   logic [XLEN-1:0] result_ff, result_in, q_fix, r_fix;

   always_comb begin
      q_fix = in_st.neg_q ? (XLEN'(0) - in_st.quo) : in_st.quo;
      r_fix = in_st.neg_r ? (XLEN'(0) - in_st.rem) : in_st.rem;
      unique case (op_type'(in_st.op))
         OP_DIV, OP_DIVU:   result_in = q_fix;
         OP_REM, OP_REMU:   result_in = r_fix;
         OP_DIVW, OP_DIVUW: result_in = sext32(q_fix);
         OP_REMW, OP_REMUW: result_in = sext32(r_fix);
         default:           result_in = in_st.res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;
endmodule
